[rtl/ec_pkg.sv]
// Shared types, constants and table builders for the envelope compander.
package ec_pkg;

    // Control bits that travel with one queued sample
    typedef struct packed {
        logic bypass;
        logic channel;
    } t_item_ctl;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENV_MUL,
        ST_ENV_UPD,
        ST_NORM,
        ST_LOG_TAB,
        ST_LOG_MUL,
        ST_LOG_ADD,
        ST_LEVEL,
        ST_SLOPE_MUL,
        ST_EXP_TAB,
        ST_EXP_MUL,
        ST_EXP_FIN,
        ST_SMOOTH_MUL,
        ST_SMOOTH_UPD,
        ST_OUT_MUL,
        ST_OUT_FIN
    } t_state;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_BYPASS    = 3'd0;
    localparam logic [2:0] REG_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_CSLOPE    = 3'd2;
    localparam logic [2:0] REG_ESLOPE    = 3'd3;
    localparam logic [2:0] REG_ATTACK    = 3'd4;
    localparam logic [2:0] REG_RELEASE   = 3'd5;

    // Register reset values
    localparam logic [22:0] THRESHOLD_RST = 23'd838861;
    localparam logic [15:0] CSLOPE_RST    = 16'd32768;
    localparam logic [15:0] ESLOPE_RST    = 16'd4096;
    localparam logic [23:0] ATTACK_RST    = 24'd16742300;
    localparam logic [23:0] RELEASE_RST   = 24'd16773721;

    // Arithmetic constants
    localparam logic [16:0] Q16_ONE     = 17'd65536;
    localparam logic [20:0] LOG2_FLOOR  = 21'd1088529;
    localparam logic [12:0] SMOOTH_KEEP = 13'd6554;

    // Integer square root, used only while building the exp table
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = 64'd0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 64'd0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // log2(1 + i/2^ld) in Q16 by repeated squaring
    function automatic logic [16:0] log_entry(input int unsigned i, input int unsigned ld);
        logic [63:0] y;
        logic [63:0] r;
        y = (64'd1 << 30) + ((64'(i) << 30) >> ld);
        r = 64'd0;
        for (int k = 0; k < 20; k++) begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= (64'd1 << 31)) begin
                y = y >> 1;
                r = r | 64'd1;
            end
        end
        return 17'((r + 64'd8) >> 4);
    endfunction

    // 2^(i/2^ld) in Q16 from iterated square roots of two
    function automatic logic [17:0] exp_entry(input int unsigned i, input int unsigned ld);
        logic [63:0] root [25];
        logic [63:0] f24;
        logic [63:0] acc;
        root[0] = 64'd1 << 31;
        for (int k = 1; k <= 24; k++) root[k] = isqrt64(root[k-1] << 30);
        f24 = (64'(i) << 24) >> ld;
        if (f24 >= (64'd1 << 24)) begin
            return 18'd131072;
        end
        acc = 64'd1 << 30;
        for (int k = 1; k <= 24; k++) begin
            if (f24[24-k]) acc = (acc * root[k]) >> 30;
        end
        return 18'((acc + 64'd8192) >> 14);
    endfunction

endpackage

[rtl/envelope_compander_core.sv]
// Top level: configuration registers and the front and back ends of the compander.
// The back end takes one sample at a time and finishes it before popping the next;
// the shared log2 unit runs twice per processed sample (5 normalize steps plus
// table, multiply and add). Bypass samples go straight to the output state, and
// the exp multiply and finish states are skipped when the gain target floors to zero.
// Reset: synchronous active low; clears envelope to zero, gain to unity, and loads
// register defaults. No clearing pass.
module envelope_compander_core #(
    parameter int SAMPLE_BITS     = 24,
    parameter int LOG_TABLE_DEPTH = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: sample_in
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   i_s_axis_tdata,
    // tuser: channel_id
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata: sample_out, gain_applied
    output logic [((SAMPLE_BITS+24)/8)*8-1:0]  o_m_axis_tdata,
    // tuser: channel_out
    output logic                               o_m_axis_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [4:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int OUT_W = ((SAMPLE_BITS + 24) / 8) * 8;

    logic        r_bypass;
    logic [22:0] r_thr;
    logic [15:0] r_cslope;
    logic [15:0] r_eslope;
    logic [23:0] r_atk;
    logic [23:0] r_rel;
    logic [2:0]  w_idx;
    logic        w_wr;

    ec_pkg::t_item_ctl        w_q_ctl;
    logic                     w_q_valid;
    logic                     w_q_pop;
    logic [SAMPLE_BITS-1:0]   w_q_sample;
    logic [SAMPLE_BITS-1:0]   w_q_mag;
    logic [SAMPLE_BITS-1:0]   w_o_sample;
    logic [16:0]              w_o_gain;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass <= 1'b0;
            r_thr    <= ec_pkg::THRESHOLD_RST;
            r_cslope <= ec_pkg::CSLOPE_RST;
            r_eslope <= ec_pkg::ESLOPE_RST;
            r_atk    <= ec_pkg::ATTACK_RST;
            r_rel    <= ec_pkg::RELEASE_RST;
        end else if (w_wr) begin
            case (w_idx)
                ec_pkg::REG_BYPASS:    r_bypass <= pwdata[0];
                ec_pkg::REG_THRESHOLD: r_thr    <= pwdata[22:0];
                ec_pkg::REG_CSLOPE:    r_cslope <= pwdata[15:0];
                ec_pkg::REG_ESLOPE:    r_eslope <= pwdata[15:0];
                ec_pkg::REG_ATTACK:    r_atk    <= pwdata[23:0];
                ec_pkg::REG_RELEASE:   r_rel    <= pwdata[23:0];
                default:               r_bypass <= r_bypass;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (w_idx)
            ec_pkg::REG_BYPASS:    prdata = {31'd0, r_bypass};
            ec_pkg::REG_THRESHOLD: prdata = {9'd0, r_thr};
            ec_pkg::REG_CSLOPE:    prdata = {16'd0, r_cslope};
            ec_pkg::REG_ESLOPE:    prdata = {16'd0, r_eslope};
            ec_pkg::REG_ATTACK:    prdata = {8'd0, r_atk};
            ec_pkg::REG_RELEASE:   prdata = {8'd0, r_rel};
            default:               prdata = 32'd0;
        endcase
    end

    ec_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (i_s_axis_tvalid),
        .o_s_ready  (o_s_axis_tready),
        .i_channel  (i_s_axis_tuser),
        .i_sample   (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_bypass   (r_bypass),
        .o_q_valid  (w_q_valid),
        .i_q_pop    (w_q_pop),
        .o_q_ctl    (w_q_ctl),
        .o_q_sample (w_q_sample),
        .o_q_mag    (w_q_mag)
    );

    ec_back #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .o_q_pop    (w_q_pop),
        .i_q_ctl    (w_q_ctl),
        .i_q_sample (w_q_sample),
        .i_q_mag    (w_q_mag),
        .i_threshold(r_thr),
        .i_cslope   (r_cslope),
        .i_eslope   (r_eslope),
        .i_attack   (r_atk),
        .i_release  (r_rel),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_channel  (o_m_axis_tuser),
        .o_sample   (w_o_sample),
        .o_gain     (w_o_gain)
    );

    assign o_m_axis_tdata = OUT_W'({w_o_gain, w_o_sample});

endmodule

[rtl/ec_front.sv]
// Front end: accepts samples, classifies them and queues them for the back end.
module ec_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_valid,
    output logic                   o_s_ready,
    input  logic                   i_channel,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_bypass,
    output logic                   o_q_valid,
    input  logic                   i_q_pop,
    output ec_pkg::t_item_ctl      o_q_ctl,
    output logic [SAMPLE_BITS-1:0] o_q_sample,
    output logic [SAMPLE_BITS-1:0] o_q_mag
);

    ec_pkg::t_item_ctl      r_ctl [2];
    logic [SAMPLE_BITS-1:0] r_smp [2];
    logic [SAMPLE_BITS-1:0] r_mag [2];
    logic                   r_wp;
    logic                   r_rp;
    logic [1:0]             r_cnt;
    logic                   w_push;
    logic                   w_pop;
    logic [SAMPLE_BITS-1:0] w_mag;

    // Magnitude of the incoming sample; full-scale negative maps to 2^(N-1)
    assign w_mag = i_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_sample) : i_sample;

    assign o_s_ready = (r_cnt != 2'd2);
    assign w_push    = i_s_valid && o_s_ready;
    assign w_pop     = i_q_pop && o_q_valid;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ctl[r_wp] <= '{bypass: i_bypass, channel: i_channel};
            r_smp[r_wp] <= i_sample;
            r_mag[r_wp] <= w_mag;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_ctl    = r_ctl[r_rp];
    assign o_q_sample = r_smp[r_rp];
    assign o_q_mag    = r_mag[r_rp];

endmodule

[rtl/ec_back.sv]
// Back end: envelope, log-domain gain curve, gain smoothing and output scaling.
module ec_back #(
    parameter int SAMPLE_BITS     = 24,
    parameter int LOG_TABLE_DEPTH = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    output logic                   o_q_pop,
    input  ec_pkg::t_item_ctl      i_q_ctl,
    input  logic [SAMPLE_BITS-1:0] i_q_sample,
    input  logic [SAMPLE_BITS-1:0] i_q_mag,
    input  logic [22:0]            i_threshold,
    input  logic [15:0]            i_cslope,
    input  logic [15:0]            i_eslope,
    input  logic [23:0]            i_attack,
    input  logic [23:0]            i_release,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_channel,
    output logic [SAMPLE_BITS-1:0] o_sample,
    output logic [16:0]            o_gain
);

    localparam int SB     = SAMPLE_BITS;
    localparam int LD     = $clog2(LOG_TABLE_DEPTH);
    localparam int PW     = (SB + 24 > 48) ? SB + 24 : 48;
    localparam int L_OFFS = (24 - SAMPLE_BITS) * 65536;

    // Constant log2 and exp2 tables
    logic [16:0] w_log_tab [LOG_TABLE_DEPTH+1];
    logic [17:0] w_exp_tab [LOG_TABLE_DEPTH+1];

    for (genvar gi = 0; gi <= LOG_TABLE_DEPTH; gi++) begin : g_tab
        localparam logic [16:0] LOG_V = ec_pkg::log_entry(gi, LD);
        localparam logic [17:0] EXP_V = ec_pkg::exp_entry(gi, LD);
        assign w_log_tab[gi] = LOG_V;
        assign w_exp_tab[gi] = EXP_V;
    end

    ec_pkg::t_state    r_state;
    ec_pkg::t_state    n_state;
    ec_pkg::t_item_ctl r_ctl;
    logic [SB-1:0]     r_sample;
    logic [SB-1:0]     r_mag;
    logic [SB-1:0]     r_env;
    logic [16:0]       r_gain;
    logic [PW-1:0]     r_prod;
    logic              r_up;
    logic [31:0]       r_x;
    logic [4:0]        r_sh;
    logic [2:0]        r_step;
    logic              r_which;
    logic [17:0]       r_lo;
    logic [17:0]       r_diff;
    logic [30:0]       r_rem;
    logic [22:0]       r_lenv;
    logic [22:0]       r_lthr;
    logic [22:0]       r_mop;
    logic [15:0]       r_slope;
    logic              r_comp;
    logic [4:0]        r_ish;
    logic [17:0]       r_target;
    logic              r_neg;
    logic              r_ovalid;
    logic              r_ochan;
    logic [SB-1:0]     r_osample;
    logic [16:0]       r_ogain;

    logic [22:0]       w_thr;
    logic              w_slot;
    logic [31:0]       w_nx;
    logic [4:0]        w_nsh;
    logic [30:0]       w_f;
    logic [LD-1:0]     w_lidx;
    logic [30:0]       w_lrem;
    logic [16:0]       w_llo;
    logic [16:0]       w_lhi;
    logic [22:0]       w_lval;
    logic [SB-1:0]     w_ediff_in;
    logic [23:0]       w_coeff;
    logic [SB-1:0]     w_env_new;
    logic [24:0]       w_L;
    logic [24:0]       w_nL;
    logic              w_gt;
    logic [26:0]       w_M;
    logic [4:0]        w_ish;
    logic [26:0]       w_fr27;
    logic [15:0]       w_frac;
    logic [LD-1:0]     w_eidx;
    logic [15:0]       w_erem;
    logic [17:0]       w_elo;
    logic [17:0]       w_ehi;
    logic [17:0]       w_v;
    logic [18:0]       w_d;
    logic [17:0]       w_ad;
    logic [18:0]       w_rr;
    logic [18:0]       w_g;
    logic [SB:0]       w_or;
    logic [SB-1:0]     w_osat;

    assign w_thr  = (i_threshold == 23'd0) ? 23'd1 : i_threshold;
    assign w_slot = !r_ovalid || i_ready;

    // Normalization step: shift out leading zeros 16, 8, 4, 2, 1 at a time
    always_comb begin
        w_nx  = r_x;
        w_nsh = r_sh;
        case (r_step)
            3'd0: if (r_x[31:16] == 16'd0) begin w_nx = r_x << 16; w_nsh = r_sh + 5'd16; end
            3'd1: if (r_x[31:24] == 8'd0)  begin w_nx = r_x << 8;  w_nsh = r_sh + 5'd8;  end
            3'd2: if (r_x[31:28] == 4'd0)  begin w_nx = r_x << 4;  w_nsh = r_sh + 5'd4;  end
            3'd3: if (r_x[31:30] == 2'd0)  begin w_nx = r_x << 2;  w_nsh = r_sh + 5'd2;  end
            3'd4: if (r_x[31] == 1'b0)     begin w_nx = r_x << 1;  w_nsh = r_sh + 5'd1;  end
            default: begin
                w_nx  = r_x;
                w_nsh = r_sh;
            end
        endcase
    end

    // Log table lookup on the normalized mantissa
    assign w_f    = r_x[30:0];
    assign w_lidx = w_f[30 -: LD];
    assign w_lrem = {w_f[30-LD:0], {LD{1'b0}}};
    assign w_llo  = w_log_tab[{1'b0, w_lidx}];
    assign w_lhi  = w_log_tab[{1'b0, w_lidx} + (LD+1)'(1)];
    assign w_lval = 23'({5'(5'd31 - r_sh), 16'd0}) + 23'(r_lo) + 23'(r_prod[47:31]);

    // Envelope update
    assign w_ediff_in = (r_mag > r_env) ? r_mag - r_env : r_env - r_mag;
    assign w_coeff    = (r_mag > r_env) ? i_attack : i_release;
    assign w_env_new  = r_up ? r_mag - r_prod[SB+23:24] : r_mag + r_prod[SB+23:24];

    // Level ratio in log2 domain and the threshold side
    assign w_L  = {2'b00, r_lenv} - {2'b00, r_lthr} + 25'(L_OFFS);
    assign w_nL = -w_L;
    assign w_gt = {1'b0, r_env, 23'd0} > (SB+24)'({w_thr, {(SB-1){1'b0}}});

    // Exponent split into shift and table fraction
    assign w_M     = r_comp ? 27'(r_prod[38:16]) : r_prod[38:12];
    assign w_ish   = 5'((w_M + 27'hFFFF) >> 16);
    assign w_fr27  = {6'd0, w_ish, 16'd0} - w_M;
    assign w_frac  = w_fr27[15:0];
    assign w_eidx  = w_frac[15 -: LD];
    assign w_erem  = {w_frac[15-LD:0], {LD{1'b0}}};
    assign w_elo   = w_exp_tab[{1'b0, w_eidx}];
    assign w_ehi   = w_exp_tab[{1'b0, w_eidx} + (LD+1)'(1)];
    assign w_v     = r_lo + r_prod[33:16];

    // Smoothing toward the target gain
    assign w_d  = {2'b00, r_gain} - {1'b0, r_target};
    assign w_ad = w_d[18] ? 18'(-w_d) : w_d[17:0];
    assign w_rr = 19'((r_prod[30:0] + 31'd32768) >> 16);
    assign w_g  = r_neg ? {1'b0, r_target} - w_rr : {1'b0, r_target} + w_rr;

    // Output rounding and saturation
    assign w_or = (SB+1)'((r_prod[SB+16:0] + (SB+17)'(32768)) >> 16);
    always_comb begin
        if (r_sample[SB-1]) begin
            if (w_or > (SB+1)'(1) << (SB-1)) w_osat = {1'b1, {(SB-1){1'b0}}};
            else                             w_osat = SB'(-w_or);
        end else begin
            if (w_or > (SB+1)'({(SB-1){1'b1}})) w_osat = {1'b0, {(SB-1){1'b1}}};
            else                                w_osat = w_or[SB-1:0];
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ec_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ec_pkg::ST_IDLE: begin
                if (i_q_valid) n_state = i_q_ctl.bypass ? ec_pkg::ST_OUT_FIN : ec_pkg::ST_ENV_MUL;
            end
            ec_pkg::ST_ENV_MUL:    n_state = ec_pkg::ST_ENV_UPD;
            ec_pkg::ST_ENV_UPD:    n_state = ec_pkg::ST_NORM;
            ec_pkg::ST_NORM:       if (r_step == 3'd4) n_state = ec_pkg::ST_LOG_TAB;
            ec_pkg::ST_LOG_TAB:    n_state = ec_pkg::ST_LOG_MUL;
            ec_pkg::ST_LOG_MUL:    n_state = ec_pkg::ST_LOG_ADD;
            ec_pkg::ST_LOG_ADD:    n_state = r_which ? ec_pkg::ST_LEVEL : ec_pkg::ST_NORM;
            ec_pkg::ST_LEVEL:      n_state = ec_pkg::ST_SLOPE_MUL;
            ec_pkg::ST_SLOPE_MUL:  n_state = ec_pkg::ST_EXP_TAB;
            ec_pkg::ST_EXP_TAB: begin
                n_state = (w_M >= 27'(ec_pkg::LOG2_FLOOR)) ? ec_pkg::ST_SMOOTH_MUL
                                                          : ec_pkg::ST_EXP_MUL;
            end
            ec_pkg::ST_EXP_MUL:    n_state = ec_pkg::ST_EXP_FIN;
            ec_pkg::ST_EXP_FIN:    n_state = ec_pkg::ST_SMOOTH_MUL;
            ec_pkg::ST_SMOOTH_MUL: n_state = ec_pkg::ST_SMOOTH_UPD;
            ec_pkg::ST_SMOOTH_UPD: n_state = ec_pkg::ST_OUT_MUL;
            ec_pkg::ST_OUT_MUL:    n_state = ec_pkg::ST_OUT_FIN;
            ec_pkg::ST_OUT_FIN:    if (w_slot) n_state = ec_pkg::ST_IDLE;
            default:               n_state = ec_pkg::ST_IDLE;
        endcase
    end

    assign o_q_pop = (r_state == ec_pkg::ST_IDLE);

    // Persistent envelope and gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env  <= '0;
            r_gain <= ec_pkg::Q16_ONE;
        end else begin
            if (r_state == ec_pkg::ST_ENV_UPD) r_env <= w_env_new;
            if (r_state == ec_pkg::ST_SMOOTH_UPD) begin
                r_gain <= (w_g > 19'(ec_pkg::Q16_ONE)) ? ec_pkg::Q16_ONE : w_g[16:0];
            end
        end
    end

    // Working datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ec_pkg::ST_IDLE: begin
                r_ctl    <= i_q_ctl;
                r_sample <= i_q_sample;
                r_mag    <= i_q_mag;
            end
            ec_pkg::ST_ENV_MUL: begin
                r_up   <= (r_mag > r_env);
                r_prod <= PW'({24'd0, w_ediff_in} * {{SB{1'b0}}, w_coeff});
            end
            ec_pkg::ST_ENV_UPD: begin
                r_x     <= 32'(w_env_new);
                r_sh    <= 5'd0;
                r_step  <= 3'd0;
                r_which <= 1'b0;
            end
            ec_pkg::ST_NORM: begin
                r_x    <= w_nx;
                r_sh   <= w_nsh;
                r_step <= r_step + 3'd1;
            end
            ec_pkg::ST_LOG_TAB: begin
                r_lo   <= 18'(w_llo);
                r_diff <= 18'(w_lhi - w_llo);
                r_rem  <= w_lrem;
            end
            ec_pkg::ST_LOG_MUL: begin
                r_prod <= PW'({30'd0, r_diff} * {17'd0, r_rem});
            end
            ec_pkg::ST_LOG_ADD: begin
                if (r_which) begin
                    r_lthr <= w_lval;
                end else begin
                    r_lenv  <= w_lval;
                    r_x     <= 32'(w_thr);
                    r_sh    <= 5'd0;
                    r_step  <= 3'd0;
                    r_which <= 1'b1;
                end
            end
            ec_pkg::ST_LEVEL: begin
                r_comp <= w_gt;
                if (w_gt) begin
                    r_mop   <= w_L[24] ? 23'd0 : w_L[22:0];
                    r_slope <= i_cslope;
                end else begin
                    if (r_env == '0 || (w_L[24] && w_nL > 25'(ec_pkg::LOG2_FLOOR))) begin
                        r_mop <= 23'(ec_pkg::LOG2_FLOOR);
                    end else if (!w_L[24]) begin
                        r_mop <= 23'd0;
                    end else begin
                        r_mop <= w_nL[22:0];
                    end
                    r_slope <= i_eslope;
                end
            end
            ec_pkg::ST_SLOPE_MUL: begin
                r_prod <= PW'({16'd0, r_mop} * {23'd0, r_slope});
            end
            ec_pkg::ST_EXP_TAB: begin
                r_target <= 18'd0;
                r_lo     <= w_elo;
                r_diff   <= w_ehi - w_elo;
                r_rem    <= 31'(w_erem);
                r_ish    <= w_ish;
            end
            ec_pkg::ST_EXP_MUL: begin
                r_prod <= PW'({16'd0, r_diff} * {18'd0, r_rem[15:0]});
            end
            ec_pkg::ST_EXP_FIN: begin
                r_target <= w_v >> r_ish;
            end
            ec_pkg::ST_SMOOTH_MUL: begin
                r_neg  <= w_d[18];
                r_prod <= PW'({13'd0, w_ad} * {18'd0, ec_pkg::SMOOTH_KEEP});
            end
            ec_pkg::ST_OUT_MUL: begin
                r_prod <= PW'({17'd0, r_mag} * {{SB{1'b0}}, r_gain});
            end
            default: begin
                r_up <= r_up;
            end
        endcase
    end

    // Output register: load on finish, hold until the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ec_pkg::ST_OUT_FIN && w_slot) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ec_pkg::ST_OUT_FIN && w_slot) begin
            r_ochan   <= r_ctl.channel;
            r_osample <= r_ctl.bypass ? r_sample : w_osat;
            r_ogain   <= r_ctl.bypass ? ec_pkg::Q16_ONE : r_gain;
        end
    end

    assign o_valid   = r_ovalid;
    assign o_channel = r_ochan;
    assign o_sample  = r_osample;
    assign o_gain    = r_ogain;

    // Smoothed gain never exceeds unity
    a_gain_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= ec_pkg::Q16_ONE)
        else $error("smoothed gain above unity");

    // A new result appears only from the finish state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == ec_pkg::ST_OUT_FIN)
        else $error("result loaded outside finish state");

    // A popped item always leaves idle
    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ec_pkg::ST_IDLE && i_q_valid) |=> r_state != ec_pkg::ST_IDLE)
        else $error("item popped but sequencer stayed idle");

    // Envelope holds outside its update state
    a_env_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state) != ec_pkg::ST_ENV_UPD && $past(i_rst_n) |-> $stable(r_env))
        else $error("envelope changed outside update");

endmodule
